>>> src/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg
// Types and constants shared by the RV32I integer execute block.
// ----------------------------------------------------------------------------
package rvie_pkg;

  localparam int XLEN = 32;

  typedef enum logic [3:0] {
    K_LOAD   = 4'd0,
    K_STORE  = 4'd1,
    K_OPIMM  = 4'd2,
    K_OP     = 4'd3,
    K_LUI    = 4'd4,
    K_AUIPC  = 4'd5,
    K_JAL    = 4'd6,
    K_JALR   = 4'd7,
    K_BRANCH = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLASS = 2'd1,
    ST_FUNC3 = 2'd2,
    ST_FUNC7 = 2'd3
  } status_t;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
  localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFF_FFFE;

  typedef struct packed {
    kind_t           kind;
    logic [2:0]      func3;
    logic [6:0]      func7;
    logic [XLEN-1:0] imm;
  } op_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            we;
    logic [XLEN-1:0] value;
    logic            taken;
    status_t         status;
  } res_t;

endpackage

>>> src/rvie_if.sv
// ----------------------------------------------------------------------------
// rvie_in_if / rvie_out_if
// Valid/ready channels for decoded instruction words and result words.
// ----------------------------------------------------------------------------
interface rvie_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [2:0]  func3;
  logic [6:0]  func7;
  logic [4:0]  src1_index;
  logic [4:0]  src2_index;
  logic [4:0]  dest_index;
  logic [31:0] immediate;

  modport source (output valid, kind, func3, func7, src1_index, src2_index, dest_index,
                  immediate, input ready);
  modport sink   (input valid, kind, func3, func7, src1_index, src2_index, dest_index,
                  immediate, output ready);
endinterface

interface rvie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        write_enable;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  logic        branch_taken;
  logic [1:0]  status;

  modport source (output valid, next_pc, write_enable, write_index, write_value,
                  branch_taken, status, input ready);
  modport sink   (input valid, next_pc, write_enable, write_index, write_value,
                  branch_taken, status, output ready);
endinterface

>>> src/rvie_ram.sv
// ----------------------------------------------------------------------------
// rvie_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rvie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/rvie_alu.sv
// ----------------------------------------------------------------------------
// rvie_alu
// ALU, branch compare and next-PC logic for one instruction.
// ----------------------------------------------------------------------------
module rvie_alu (
  input  rvie_pkg::op_t       op,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  logic [31:0]         pc,
  input  logic                dest_ok,
  output rvie_pkg::res_t      res
);
  import rvie_pkg::*;

  logic [XLEN-1:0] val;
  logic [XLEN-1:0] npc;
  logic [XLEN-1:0] opb;
  logic [XLEN-1:0] upper;
  logic [4:0]      shamt;
  logic            wr;
  logic            taken;
  logic            cond;
  logic            lt_s;
  logic            lt_u;
  status_t         st;

  assign opb   = (op.kind == K_OPIMM) ? op.imm : b;
  assign shamt = opb[4:0];
  assign lt_s  = $signed(a) < $signed(opb);
  assign lt_u  = a < opb;
  assign upper = {op.imm[19:0], 12'd0};

  always_comb begin
    val   = '0;
    npc   = pc + PC_STEP;
    wr    = 1'b0;
    taken = 1'b0;
    cond  = 1'b0;
    st    = ST_OK;
    unique case (op.kind)
      K_LOAD, K_STORE: begin
      end
      K_OPIMM, K_OP: begin
        wr = 1'b1;
        if (op.kind == K_OP && op.func7 == F7_ALT && op.func3 == F3_ADD) begin
          val = a - opb;
        end else if (op.func7 == F7_ALT && op.func3 == F3_SR) begin
          val = XLEN'($signed(a) >>> shamt);
        end else if (op.func7 != F7_BASE
                     && (op.kind == K_OP || op.func3 == F3_SLL || op.func3 == F3_SR)) begin
          st = ST_FUNC7;
        end else begin
          unique case (op.func3)
            F3_ADD:  val = a + opb;
            F3_SLL:  val = a << shamt;
            F3_SLT:  val = {31'd0, lt_s};
            F3_SLTU: val = {31'd0, lt_u};
            F3_XOR:  val = a ^ opb;
            F3_SR:   val = a >> shamt;
            F3_OR:   val = a | opb;
            F3_AND:  val = a & opb;
            default: val = '0;
          endcase
        end
      end
      K_LUI: begin
        wr  = 1'b1;
        val = upper;
      end
      K_AUIPC: begin
        wr  = 1'b1;
        val = pc + upper;
      end
      K_JAL: begin
        wr    = 1'b1;
        val   = pc + PC_STEP;
        npc   = pc + op.imm;
        taken = 1'b1;
      end
      K_JALR: begin
        wr    = 1'b1;
        val   = pc + PC_STEP;
        npc   = (a + op.imm) & JALR_MASK;
        taken = 1'b1;
      end
      K_BRANCH: begin
        unique case (op.func3)
          F3_BEQ:  cond = (a == b);
          F3_BNE:  cond = (a != b);
          F3_BLT:  cond = lt_s;
          F3_BGE:  cond = !lt_s;
          F3_BLTU: cond = lt_u;
          F3_BGEU: cond = !lt_u;
          default: st = ST_FUNC3;
        endcase
        if (cond) begin
          npc   = pc + op.imm;
          taken = 1'b1;
        end
      end
      default: st = ST_CLASS;
    endcase
    if (st != ST_OK) begin
      wr    = 1'b0;
      taken = 1'b0;
      npc   = pc;
    end
    if (!dest_ok) begin
      wr = 1'b0;
    end
    res.next_pc = npc;
    res.we      = wr;
    res.value   = wr ? val : '0;
    res.taken   = taken;
    res.status  = st;
  end

endmodule

>>> src/rv32i_integer_execute.sv
// Pipeline: an accepted word is registered into stage s1, and its result word into
// the output register. Throughput: one word per cycle while the result channel does not
// stall; the register file RAMs are read at acceptance and written as the instruction
// retires, with the last write forwarded. Reset: entry valid flags cleared (all
// registers read zero), PC set to zero, pipeline emptied.
// ----------------------------------------------------------------------------
// rv32i_integer_execute
// RV32I integer execute unit: register file in RAM, ALU, branches and PC.
// ----------------------------------------------------------------------------
module rv32i_integer_execute #(
  parameter int REG_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  rvie_in_if.sink     in_port,
  rvie_out_if.source  out_port
);
  import rvie_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  logic            s1_valid_r;
  op_t             s1_op_r;
  logic [4:0]      s1_rs1_r;
  logic [4:0]      s1_rs2_r;
  logic [4:0]      s1_rd_r;
  logic            s1_v1_r;
  logic            s1_v2_r;
  logic [XLEN-1:0] pc_r;
  logic            vld_r [REG_COUNT];
  logic            wb_vld_r;
  logic [4:0]      wb_idx_r;
  logic [XLEN-1:0] wb_val_r;

  logic            out_valid_r;
  res_t            out_res_r;
  logic [4:0]      out_idx_r;

  logic            accept;
  logic            s1_adv;
  logic            rs1_ok;
  logic            rs2_ok;
  logic            dest_ok;
  logic [XLEN-1:0] ram1_q;
  logic [XLEN-1:0] ram2_q;
  logic [XLEN-1:0] opa;
  logic [XLEN-1:0] opb;
  logic            wr_go;
  res_t            res;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_port.ready);
  assign in_port.ready = rst_n && (!s1_valid_r || s1_adv);
  assign accept        = in_port.valid && in_port.ready;
  assign rs1_ok        = 6'(in_port.src1_index) < 6'(REG_COUNT);
  assign rs2_ok        = 6'(in_port.src2_index) < 6'(REG_COUNT);
  assign dest_ok       = (s1_rd_r != 5'd0) && (6'(s1_rd_r) < 6'(REG_COUNT));
  assign wr_go         = s1_adv && res.we;

  rvie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_a (
    .clk   (clk),
    .we    (wr_go),
    .waddr (s1_rd_r[AW-1:0]),
    .wdata (res.value),
    .re    (accept),
    .raddr (in_port.src1_index[AW-1:0]),
    .rdata (ram1_q)
  );

  rvie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_b (
    .clk   (clk),
    .we    (wr_go),
    .waddr (s1_rd_r[AW-1:0]),
    .wdata (res.value),
    .re    (accept),
    .raddr (in_port.src2_index[AW-1:0]),
    .rdata (ram2_q)
  );

  always_comb begin
    if (wb_vld_r && wb_idx_r == s1_rs1_r) begin
      opa = wb_val_r;
    end else begin
      opa = s1_v1_r ? ram1_q : '0;
    end
    if (wb_vld_r && wb_idx_r == s1_rs2_r) begin
      opb = wb_val_r;
    end else begin
      opb = s1_v2_r ? ram2_q : '0;
    end
  end

  rvie_alu u_alu (
    .op      (s1_op_r),
    .a       (opa),
    .b       (opb),
    .pc      (pc_r),
    .dest_ok (dest_ok),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r.kind  <= kind_t'(in_port.kind);
      s1_op_r.func3 <= in_port.func3;
      s1_op_r.func7 <= in_port.func7;
      s1_op_r.imm   <= in_port.immediate;
      s1_rs1_r      <= in_port.src1_index;
      s1_rs2_r      <= in_port.src2_index;
      s1_rd_r       <= in_port.dest_index;
      s1_v1_r       <= rs1_ok && vld_r[in_port.src1_index[AW-1:0]];
      s1_v2_r       <= rs2_ok && vld_r[in_port.src2_index[AW-1:0]];
    end
    if (s1_adv) begin
      out_res_r <= res;
      out_idx_r <= res.we ? s1_rd_r : 5'd0;
    end
    if (wr_go) begin
      wb_idx_r <= s1_rd_r;
      wb_val_r <= res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wb_vld_r    <= 1'b0;
      pc_r        <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      if (in_port.ready) begin
        s1_valid_r <= in_port.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end else if (s1_adv) begin
        pc_r <= res.next_pc;
      end
      if (wr_go) begin
        wb_vld_r               <= 1'b1;
        vld_r[s1_rd_r[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign out_port.valid        = out_valid_r;
  assign out_port.next_pc      = out_res_r.next_pc;
  assign out_port.write_enable = out_res_r.we;
  assign out_port.write_index  = out_idx_r;
  assign out_port.write_value  = out_res_r.value;
  assign out_port.branch_taken = out_res_r.taken;
  assign out_port.status       = out_res_r.status;

endmodule

>>> src/rvie_checker.sv
// ----------------------------------------------------------------------------
// rvie_checker
// Port-level checks on the execute unit's result channel, bound to the top.
// ----------------------------------------------------------------------------
module rvie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_enable,
  input logic [4:0]  out_write_index,
  input logic [31:0] out_write_value,
  input logic        out_branch_taken,
  input logic [1:0]  out_status
);
  import rvie_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_write_enable && !out_branch_taken)
    else $error("error word writes or redirects");

  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_write_index != 5'd0)
    else $error("write to x0 reported");

  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_write_index == 5'd0 && out_write_value == 32'd0)
    else $error("idle write fields not zero");

endmodule

bind rv32i_integer_execute rvie_checker u_rvie_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_port.valid),
  .out_ready        (out_port.ready),
  .out_write_enable (out_port.write_enable),
  .out_write_index  (out_port.write_index),
  .out_write_value  (out_port.write_value),
  .out_branch_taken (out_port.branch_taken),
  .out_status       (out_port.status)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV32I integer execute block. A directed table
// walks the extremes, the error statuses and most operations, then random
// instruction words run over several start PC settings. Every result word is
// checked against the table's expected word or an in-bench model of the register
// file and PC, with random stalls on both channels except in the second phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rvie_pkg::*;

  localparam logic [3:0] K_BAD_FIRST = 4'd9;
  localparam logic [3:0] K_BAD_LAST  = 4'd15;
  localparam logic [2:0] F3_BR_BAD   = 3'd2;
  localparam logic [6:0] F7_BAD      = 7'h7F;
  localparam int         DIR_ROWS    = 26;
  localparam int         PHASES      = 4;
  localparam int         PHASE_WORDS = 200;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  func3;
    logic [6:0]  func7;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [4:0]  dest_index;
    logic [31:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        write_enable;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        branch_taken;
    status_t     status;
  } retire_t;

  typedef struct packed {
    instr_t  w;
    logic    typed;
    retire_t want;
  } row_t;

  localparam retire_t NOT_TYPED = '0;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        idling;
  int          mismatches;

  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  retire_t     pending_retires [$];

  rvie_in_if  in_if ();
  rvie_out_if out_if ();

  rv32i_integer_execute #(.REG_COUNT(32)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_port  (in_if),
    .out_port (out_if)
  );

  row_t dir_rows [DIR_ROWS] = '{
    '{'{K_BAD_LAST, F3_ADD, F7_BASE, 5'd0, 5'd0, 5'd7, 32'h1234_5678}, 1'b1,
      '{32'd0, 1'b0, 5'd0, 32'd0, 1'b0, ST_CLASS}},
    '{'{K_LUI, F3_ADD, F7_BASE, 5'd0, 5'd0, 5'd1, 32'h000F_FFFF}, 1'b1,
      '{32'd4, 1'b1, 5'd1, 32'hFFFF_F000, 1'b0, ST_OK}},
    '{'{K_OPIMM, F3_ADD, F7_BASE, 5'd0, 5'd0, 5'd2, 32'h7FFF_FFFF}, 1'b1,
      '{32'd8, 1'b1, 5'd2, 32'h7FFF_FFFF, 1'b0, ST_OK}},
    '{'{K_OPIMM, F3_ADD, F7_BASE, 5'd0, 5'd0, 5'd3, 32'h8000_0000}, 1'b1,
      '{32'd12, 1'b1, 5'd3, 32'h8000_0000, 1'b0, ST_OK}},
    '{'{K_OP, F3_ADD, F7_BASE, 5'd2, 5'd3, 5'd4, 32'd0}, 1'b1,
      '{32'd16, 1'b1, 5'd4, 32'hFFFF_FFFF, 1'b0, ST_OK}},
    '{'{K_OPIMM, F3_SLL, F7_BAD, 5'd4, 5'd0, 5'd5, 32'd1}, 1'b1,
      '{32'd16, 1'b0, 5'd0, 32'd0, 1'b0, ST_FUNC7}},
    '{'{K_OP, F3_ADD, F7_BAD, 5'd2, 5'd3, 5'd6, 32'd0}, 1'b1,
      '{32'd16, 1'b0, 5'd0, 32'd0, 1'b0, ST_FUNC7}},
    '{'{K_BRANCH, F3_BR_BAD, F7_BASE, 5'd0, 5'd0, 5'd0, 32'd8}, 1'b1,
      '{32'd16, 1'b0, 5'd0, 32'd0, 1'b0, ST_FUNC3}},
    '{'{K_BAD_FIRST, F3_ADD, F7_BASE, 5'd1, 5'd2, 5'd9, 32'd4}, 1'b1,
      '{32'd16, 1'b0, 5'd0, 32'd0, 1'b0, ST_CLASS}},
    '{'{K_OPIMM, F3_ADD, F7_BASE, 5'd4, 5'd0, 5'd0, 32'd5}, 1'b1,
      '{32'd20, 1'b0, 5'd0, 32'd0, 1'b0, ST_OK}},
    '{'{K_OP, F3_ADD, F7_ALT, 5'd3, 5'd2, 5'd5, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_OP, F3_SLT, F7_BASE, 5'd3, 5'd2, 5'd6, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_OPIMM, F3_SLT, F7_BAD, 5'd4, 5'd0, 5'd8, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_OPIMM, F3_SLTU, F7_BASE, 5'd4, 5'd0, 5'd9, 32'hFFFF_FFFF}, 1'b0, NOT_TYPED},
    '{'{K_OPIMM, F3_SR, F7_ALT, 5'd3, 5'd0, 5'd10, 32'd31}, 1'b0, NOT_TYPED},
    '{'{K_OPIMM, F3_SR, F7_BASE, 5'd4, 5'd0, 5'd11, 32'hFFFF_FFFF}, 1'b0, NOT_TYPED},
    '{'{K_OP, F3_SR, F7_ALT, 5'd3, 5'd4, 5'd12, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_OPIMM, F3_XOR, F7_BASE, 5'd4, 5'd0, 5'd14, 32'h5555_5555}, 1'b0, NOT_TYPED},
    '{'{K_OP, F3_OR, F7_BASE, 5'd2, 5'd3, 5'd15, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_AUIPC, F3_ADD, F7_BASE, 5'd0, 5'd0, 5'd17, 32'h000F_FFFF}, 1'b0, NOT_TYPED},
    '{'{K_JALR, F3_ADD, F7_BASE, 5'd4, 5'd0, 5'd18, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_JAL, F3_ADD, F7_BASE, 5'd0, 5'd0, 5'd31, 32'h8000_0000}, 1'b0, NOT_TYPED},
    '{'{K_BRANCH, F3_BLT, F7_BASE, 5'd3, 5'd2, 5'd0, 32'd16}, 1'b0, NOT_TYPED},
    '{'{K_BRANCH, F3_BGEU, F7_BASE, 5'd3, 5'd2, 5'd0, 32'hFFFF_FFF8}, 1'b0, NOT_TYPED},
    '{'{K_LOAD, F3_ADD, F7_BASE, 5'd1, 5'd2, 5'd20, 32'd0}, 1'b0, NOT_TYPED},
    '{'{K_STORE, F3_AND, F7_BAD, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF}, 1'b0, NOT_TYPED}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic retire_t execute_word(input instr_t w);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc_now;
    logic [31:0] npc;
    logic [31:0] val;
    logic        wr;
    logic        taken;
    logic        cond;
    status_t     st;
    retire_t     r;
    a      = arch_regs[w.src1_index];
    b      = arch_regs[w.src2_index];
    pc_now = arch_pc;
    npc    = pc_now + PC_STEP;
    val    = '0;
    wr     = 1'b0;
    taken  = 1'b0;
    cond   = 1'b0;
    st     = ST_OK;
    case (w.kind)
      K_LOAD, K_STORE: ;
      K_OPIMM: begin
        wr = 1'b1;
        case (w.func3)
          F3_ADD:  val = a + w.immediate;
          F3_SLT:  val = ($signed(a) < $signed(w.immediate)) ? 32'd1 : 32'd0;
          F3_SLTU: val = (a < w.immediate) ? 32'd1 : 32'd0;
          F3_XOR:  val = a ^ w.immediate;
          F3_OR:   val = a | w.immediate;
          F3_AND:  val = a & w.immediate;
          F3_SLL: begin
            if (w.func7 != F7_BASE) st = ST_FUNC7;
            else val = a << w.immediate[4:0];
          end
          default: begin
            if (w.func7 == F7_BASE) val = a >> w.immediate[4:0];
            else if (w.func7 == F7_ALT) val = $signed(a) >>> w.immediate[4:0];
            else st = ST_FUNC7;
          end
        endcase
      end
      K_OP: begin
        wr = 1'b1;
        if (w.func7 == F7_ALT && w.func3 == F3_ADD) val = a - b;
        else if (w.func7 == F7_ALT && w.func3 == F3_SR) val = $signed(a) >>> b[4:0];
        else if (w.func7 != F7_BASE) st = ST_FUNC7;
        else begin
          case (w.func3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[4:0];
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[4:0];
            F3_OR:   val = a | b;
            default: val = a & b;
          endcase
        end
      end
      K_LUI: begin
        wr  = 1'b1;
        val = {w.immediate[19:0], 12'h000};
      end
      K_AUIPC: begin
        wr  = 1'b1;
        val = pc_now + {w.immediate[19:0], 12'h000};
      end
      K_JAL: begin
        wr    = 1'b1;
        val   = pc_now + PC_STEP;
        npc   = pc_now + w.immediate;
        taken = 1'b1;
      end
      K_JALR: begin
        wr    = 1'b1;
        val   = pc_now + PC_STEP;
        npc   = (a + w.immediate) & JALR_MASK;
        taken = 1'b1;
      end
      K_BRANCH: begin
        case (w.func3)
          F3_BEQ:  cond = (a == b);
          F3_BNE:  cond = (a != b);
          F3_BLT:  cond = ($signed(a) < $signed(b));
          F3_BGE:  cond = !($signed(a) < $signed(b));
          F3_BLTU: cond = (a < b);
          F3_BGEU: cond = (a >= b);
          default: st = ST_FUNC3;
        endcase
        if (cond) begin
          npc   = pc_now + w.immediate;
          taken = 1'b1;
        end
      end
      default: st = ST_CLASS;
    endcase
    if (st != ST_OK) begin
      wr    = 1'b0;
      taken = 1'b0;
      val   = '0;
      npc   = pc_now;
    end
    // drop writes to x0
    if (wr && w.dest_index == 5'd0) wr = 1'b0;
    if (wr) arch_regs[w.dest_index] = val;
    arch_pc = npc;
    r = '{npc, wr, wr ? w.dest_index : 5'd0, wr ? val : 32'd0, taken, st};
    return r;
  endfunction

  function automatic instr_t random_word();
    instr_t      w;
    logic [31:0] t;
    if ($urandom_range(0, 99) < 4) begin
      w.kind = 4'($urandom_range(K_BAD_FIRST, K_BAD_LAST));
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:       w.kind = K_OPIMM;
        6, 7, 8, 9, 10, 11:     w.kind = K_OP;
        12:                     w.kind = K_LUI;
        13:                     w.kind = K_AUIPC;
        14:                     w.kind = K_JAL;
        15:                     w.kind = K_JALR;
        16, 17, 18:             w.kind = K_BRANCH;
        default:                w.kind = $urandom_range(0, 1) ? K_LOAD : K_STORE;
      endcase
    end
    w.func3 = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: w.func7 = F7_BASE;
      5, 6, 7:       w.func7 = F7_ALT;
      default:       w.func7 = 7'($urandom_range(0, 127));
    endcase
    w.src1_index = 5'($urandom_range(0, 31));
    w.src2_index = 5'($urandom_range(0, 31));
    w.dest_index = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0: begin
        t = $urandom_range(0, 31);
        w.immediate = t - 32'd16;
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       w.immediate = 32'h0000_0000;
          1:       w.immediate = 32'hFFFF_FFFF;
          2:       w.immediate = 32'h7FFF_FFFF;
          default: w.immediate = 32'h8000_0000;
        endcase
      end
      default: w.immediate = $urandom;
    endcase
    return w;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic issue_word(input instr_t w, input logic typed, input retire_t want);
    logic    acc;
    retire_t r;
    while (idling && $urandom_range(0, 99) < 33) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= w.kind;
    in_if.func3      <= w.func3;
    in_if.func7      <= w.func7;
    in_if.src1_index <= w.src1_index;
    in_if.src2_index <= w.src2_index;
    in_if.dest_index <= w.dest_index;
    in_if.immediate  <= w.immediate;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk);
      acc = (in_if.ready === 1'b1);
      @(posedge clk);
    end
    r = execute_word(w);
    pending_retires.push_back(typed ? want : r);
  endtask

  task automatic write_start_pc(input logic [31:0] value);
    in_if.valid <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    arch_pc = value;
  endtask

  task automatic check_retire();
    retire_t want;
    if (pending_retires.size() == 0) begin
      note_mismatch("unexpected word, next_pc", out_if.next_pc, '0);
    end else begin
      want = pending_retires.pop_front();
      if (out_if.next_pc !== want.next_pc)
        note_mismatch("next_pc", out_if.next_pc, want.next_pc);
      if (out_if.write_enable !== want.write_enable)
        note_mismatch("write_enable", 32'(out_if.write_enable), 32'(want.write_enable));
      if (out_if.write_index !== want.write_index)
        note_mismatch("write_index", 32'(out_if.write_index), 32'(want.write_index));
      if (out_if.write_value !== want.write_value)
        note_mismatch("write_value", out_if.write_value, want.write_value);
      if (out_if.branch_taken !== want.branch_taken)
        note_mismatch("branch_taken", 32'(out_if.branch_taken), 32'(want.branch_taken));
      if (out_if.status !== want.status)
        note_mismatch("status", 32'(out_if.status), 32'(want.status));
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_if.ready <= !(idling && $urandom_range(0, 99) < 33);
      @(negedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_retire();
      @(posedge clk);
    end
  end

  initial begin
    int          ph;
    int          k;
    logic [31:0] seed_pc;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= '0;
    in_if.func3      <= '0;
    in_if.func7      <= '0;
    in_if.src1_index <= '0;
    in_if.src2_index <= '0;
    in_if.dest_index <= '0;
    in_if.immediate  <= '0;
    idling     = 1'b1;
    mismatches = 0;
    arch_pc    = '0;
    for (k = 0; k < 32; k++) arch_regs[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++)
      issue_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       seed_pc = 32'hFFFF_FFFF;
        1:       seed_pc = 32'h0000_0000;
        2:       seed_pc = $urandom;
        default: seed_pc = 32'hFFFF_FFFC;
      endcase
      // hold both channels busy for the whole of the second phase
      idling = (ph != 1);
      write_start_pc(seed_pc);
      for (k = 0; k < PHASE_WORDS; k++) issue_word(random_word(), 1'b0, NOT_TYPED);
    end

    in_if.valid <= 1'b0;
    while (pending_retires.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> rv32i_integer_execute.f
src/rvie_pkg.sv
src/rvie_if.sv
src/rvie_ram.sv
src/rvie_alu.sv
src/rv32i_integer_execute.sv
src/rvie_checker.sv
tb/tb_top.sv
